/* src/solid_color_frame_detector_top_macros.svh */
// assertion macros for the solid colour frame detector
`ifndef SOLID_COLOR_FRAME_DETECTOR_TOP_MACROS_SVH
`define SOLID_COLOR_FRAME_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/scfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package scfd_pkg;

  localparam int CHAN_W     = 8;
  localparam int STEP_W     = 10;
  localparam int THRESH_W   = 9;
  localparam int COUNT_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_RED        = 3'd0,
    REG_REF_GREEN      = 3'd1,
    REG_REF_BLUE       = 3'd2,
    REG_BGR_ORDER      = 3'd3,
    REG_STEP_X         = 3'd4,
    REG_STEP_Y         = 3'd5,
    REG_FILL_THRESHOLD = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_first;
    logic [CHAN_W-1:0] chan_second;
    logic [CHAN_W-1:0] chan_third;
    logic              line_end;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic               solid_color;
    logic [COUNT_W-1:0] matched_samples;
    logic [COUNT_W-1:0] total_samples;
  } result_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   ref_red;
    logic [CHAN_W-1:0]   ref_green;
    logic [CHAN_W-1:0]   ref_blue;
    logic                bgr_order;
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [THRESH_W-1:0] fill_threshold;
  } cfg_t;

  // per-pixel decision handed from the sampler to the counters
  typedef struct packed {
    logic sampled;
    logic matched;
    logic frame_end;
  } sample_ctl_t;

endpackage
`default_nettype wire

/* src/scfd_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface scfd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

/* src/scfd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module scfd_cfg_regs
  import scfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // register writes, defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_red        <= CHAN_W'(0);
      cfg_r.ref_green      <= CHAN_W'(154);
      cfg_r.ref_blue       <= CHAN_W'(0);
      cfg_r.bgr_order      <= 1'b0;
      cfg_r.step_x         <= STEP_W'(10);
      cfg_r.step_y         <= STEP_W'(10);
      cfg_r.fill_threshold <= THRESH_W'(192);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_RED:        cfg_r.ref_red        <= cfg_data[CHAN_W-1:0];
        REG_REF_GREEN:      cfg_r.ref_green      <= cfg_data[CHAN_W-1:0];
        REG_REF_BLUE:       cfg_r.ref_blue       <= cfg_data[CHAN_W-1:0];
        REG_BGR_ORDER:      cfg_r.bgr_order      <= cfg_data[0];
        REG_STEP_X:         cfg_r.step_x         <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:         cfg_r.step_y         <= cfg_data[STEP_W-1:0];
        REG_FILL_THRESHOLD: cfg_r.fill_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* src/scfd_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none
module scfd_sampler
  import scfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step_en,
  input  wire cfg_t         cfg,
  input  wire pixel_t       pix,
  output sample_ctl_t       ctl
);

  logic [STEP_W-1:0] col_phase_r, col_phase_nxt;
  logic [STEP_W-1:0] line_phase_r, line_phase_nxt;
  logic [CHAN_W-1:0] want_first, want_third;

  // step of zero counts as one; wrap once the phase reaches step minus one
  function automatic logic [STEP_W-1:0] next_phase(input logic [STEP_W-1:0] phase,
                                                   input logic [STEP_W-1:0] step);
    logic [STEP_W:0]   inc;
    logic [STEP_W-1:0] lim;
    inc = (STEP_W+1)'(phase) + (STEP_W+1)'(1);
    lim = (step == '0) ? STEP_W'(1) : step;
    if (inc >= (STEP_W+1)'(lim)) return '0;
    return inc[STEP_W-1:0];
  endfunction

  // reference channels in stream order
  assign want_first = cfg.bgr_order ? cfg.ref_blue : cfg.ref_red;
  assign want_third = cfg.bgr_order ? cfg.ref_red  : cfg.ref_blue;

  // sample and match decision
  always_comb begin
    ctl.sampled   = (col_phase_r == '0) && (line_phase_r == '0);
    ctl.matched   = (pix.chan_first == want_first) && (pix.chan_second == cfg.ref_green)
                    && (pix.chan_third == want_third);
    ctl.frame_end = pix.frame_end;
  end

  // phase update
  always_comb begin
    col_phase_nxt  = col_phase_r;
    line_phase_nxt = line_phase_r;
    priority if (pix.frame_end) begin
      col_phase_nxt  = '0;
      line_phase_nxt = '0;
    end else if (pix.line_end) begin
      col_phase_nxt  = '0;
      line_phase_nxt = next_phase(line_phase_r, cfg.step_y);
    end else begin
      col_phase_nxt  = next_phase(col_phase_r, cfg.step_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_phase_r  <= '0;
      line_phase_r <= '0;
    end else if (step_en) begin
      col_phase_r  <= col_phase_nxt;
      line_phase_r <= line_phase_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/scfd_counter.sv */
`timescale 1ns / 1ps
`default_nettype none
module scfd_counter
  import scfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire sample_ctl_t         ctl,
  input  wire logic [THRESH_W-1:0] fill_threshold,
  input  wire logic                res_ready,
  output logic                     res_valid,
  output result_t                  res
);

  localparam int PROD_W = THRESH_W + COUNT_W;

  logic [COUNT_W-1:0]  match_cnt_r, match_cnt_nxt;
  logic [COUNT_W-1:0]  sample_cnt_r, sample_cnt_nxt;
  logic [COUNT_W-1:0]  res_match_r, res_total_r;
  logic [THRESH_W-1:0] res_thresh_r;
  logic                res_valid_r;
  logic                count_en;
  logic                load;
  logic [PROD_W-1:0]   lhs, rhs;

  // counting stops once the sample count saturates
  assign count_en       = ctl.sampled && (sample_cnt_r != COUNT_MAX);
  assign match_cnt_nxt  = match_cnt_r + COUNT_W'(count_en && ctl.matched);
  assign sample_cnt_nxt = sample_cnt_r + COUNT_W'(count_en);
  assign load           = step_en && ctl.frame_end;

  // frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_cnt_r  <= '0;
      sample_cnt_r <= '0;
    end else if (load) begin
      match_cnt_r  <= '0;
      sample_cnt_r <= '0;
    end else if (step_en) begin
      match_cnt_r  <= match_cnt_nxt;
      sample_cnt_r <= sample_cnt_nxt;
    end
  end

  // result register, a new frame result may replace one taken in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (load) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_match_r  <= match_cnt_nxt;
      res_total_r  <= sample_cnt_nxt;
      res_thresh_r <= fill_threshold;
    end
  end

  // matches * 256 against threshold * samples
  assign lhs = PROD_W'({res_match_r, 8'h00});
  assign rhs = PROD_W'(res_thresh_r) * PROD_W'(res_total_r);

  assign res_valid           = res_valid_r;
  assign res.solid_color     = lhs > rhs;
  assign res.matched_samples = res_match_r;
  assign res.total_samples   = res_total_r;

endmodule
`default_nettype wire

/* src/solid_color_frame_detector_top.sv */
// flow: an accepted pixel is held in the input register and then counted in the
//   frame counters; a frame end pixel loads its result into the result register
// throughput: one pixel per cycle, set by the single counter update stage; a
//   frame end pixel waits only while the previous result is held and not taken
// reset: rst_n synchronous active low, clears phases, counters and valids and
//   loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "solid_color_frame_detector_top_macros.svh"
module solid_color_frame_detector_top
  import scfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  scfd_stream_if.sink                in_stream,
  scfd_stream_if.source              out_stream
);

  cfg_t        cfg;
  sample_ctl_t ctl;
  pixel_t      pix_r;
  logic        pix_valid_r;
  logic        proceed;
  logic        res_valid;
  result_t     res;

  scfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pixel stage moves on unless a frame end meets a result that is not taken
  assign proceed         = pix_valid_r &&
                           (!pix_r.frame_end || !res_valid || out_stream.ready);
  assign in_stream.ready = !pix_valid_r || proceed;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      pix_valid_r <= 1'b1;
    end else if (proceed) begin
      pix_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      pix_r <= in_stream.payload;
    end
  end

  scfd_sampler u_sampler (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (proceed),
    .cfg     (cfg),
    .pix     (pix_r),
    .ctl     (ctl)
  );

  scfd_counter u_counter (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (proceed),
    .ctl            (ctl),
    .fill_threshold (cfg.fill_threshold),
    .res_ready      (out_stream.ready),
    .res_valid      (res_valid),
    .res            (res)
  );

  assign out_stream.valid   = res_valid;
  assign out_stream.payload = res;

  // checks
  `SCFD_ASSERT_SAME(a_match_le_total, res_valid, res.matched_samples <= res.total_samples, "matched count above sample count")
  `SCFD_ASSERT_SAME(a_frame_has_sample, res_valid, res.total_samples != '0, "frame result with no sample")
  `SCFD_ASSERT_NEXT(a_eof_loads_result, pix_valid_r && pix_r.frame_end && !res_valid, res_valid, "frame end did not load result")

endmodule
`default_nettype wire
